[rtl/core/vssa_pkg.sv]
// Shared types and constants for the vector sort / sum / argmax unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package vssa_pkg;

    localparam int DEPTH = 64;
    localparam int VAL_W = 32;
    localparam int POS_W = 6;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } vssa_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] sorted_value;
        logic                    final_res;
        logic signed [VAL_W-1:0] total;
        logic [POS_W-1:0]        max_position;
        logic                    overflow;
    } vssa_out_t;

    // What one cell shows its neighbours.
    typedef struct packed {
        logic                    valid;
        logic                    gt;     // key sorts before this cell's value
        logic signed [VAL_W-1:0] value;
    } vssa_link_t;

    // Command broadcast along the chain.
    typedef struct packed {
        logic insert;
        logic shift;
    } vssa_op_t;

    // Per-vector results frozen on the final transfer.
    typedef struct packed {
        logic signed [VAL_W-1:0] total;
        logic [POS_W-1:0]        max_position;
        logic                    overflow;
    } vssa_snap_t;

    // Fill status of the current vector.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             full;
    } vssa_fill_t;

    // Left of cell 0: always "occupied", never larger than the key.
    localparam vssa_link_t LINK_HEAD = '{valid: 1'b1, gt: 1'b0, value: '0};
    // Right of the last cell: empty.
    localparam vssa_link_t LINK_TAIL = '{valid: 1'b0, gt: 1'b0, value: '0};

endpackage

`default_nettype wire

[rtl/core/vssa_cell.sv]
// One cell of the insertion-sort chain: holds one element and a valid bit.
// Depends on vssa_pkg.
`default_nettype none

module vssa_cell
    import vssa_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire vssa_op_t                op,
    input  wire logic signed [VAL_W-1:0] key,
    input  wire vssa_link_t              left,
    input  wire vssa_link_t              right,
    output vssa_link_t                   link
);

    logic                    valid_reg, valid_next;
    logic signed [VAL_W-1:0] value_reg, value_next;
    logic                    gt;

    assign gt   = valid_reg && (key < value_reg);
    assign link = '{valid: valid_reg, gt: gt, value: value_reg};

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (op.shift) begin
            // drain towards cell 0
            valid_next = right.valid;
            value_next = right.value;
        end else if (op.insert) begin
            if ((!valid_reg && left.valid) || gt) begin
                valid_next = 1'b1;
                value_next = left.gt ? left.value : key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

[rtl/core/vssa_stats.sv]
// Running sum, first-maximum position, fill count and drop flag per vector.
// Depends on vssa_pkg.
`default_nettype none

module vssa_stats
    import vssa_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    xfer,
    input  wire vssa_in_t                item,
    output vssa_fill_t                   fill,
    output vssa_snap_t                   snap
);

    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [VAL_W-1:0] sum_reg, sum_next;
    logic signed [VAL_W-1:0] best_reg, best_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic                    drop_reg, drop_next;
    vssa_snap_t              snap_reg;
    logic                    full;
    logic                    stored;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign stored = xfer && !full;
    assign fill   = '{count: count_reg, full: full};
    assign snap   = snap_reg;

    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        best_next  = best_reg;
        pos_next   = pos_reg;
        drop_next  = drop_reg | (xfer && full);
        if (stored) begin
            count_next = count_reg + 1'b1;
            sum_next   = sum_reg + item.value;
            if ((count_reg == '0) || (best_reg < item.value)) begin
                best_next = item.value;
                pos_next  = count_reg[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            pos_reg   <= '0;
            drop_reg  <= 1'b0;
        end else if (xfer && item.last) begin
            count_reg <= '0;
            sum_reg   <= '0;
            pos_reg   <= '0;
            drop_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            pos_reg   <= pos_next;
            drop_reg  <= drop_next;
        end
        best_reg <= best_next;
        if (xfer && item.last) begin
            snap_reg <= '{total: sum_next, max_position: pos_next, overflow: drop_next};
        end
    end

endmodule

`default_nettype wire

[rtl/core/vector_sort_sum_argmax_unit.sv]
// Top level of the vector sort / sum / argmax unit.
// Depends on vssa_pkg, vssa_cell and vssa_stats.
//
// Usage:
//   s_valid/s_ready/s_data carry one signed 32-bit element per transfer;
//   s_data.last closes the vector (at least one element per vector).
//   Elements are inserted into a chain of DEPTH sorting cells as they
//   arrive, one per cycle while loading. Elements beyond DEPTH are dropped
//   and flagged. After the last transfer the chain drains from cell 0 into
//   the output register, one result per unstalled cycle: ascending values,
//   final_res on the last, and in every result the wrapping sum, the load
//   position of the first greatest element and the overflow flag.
// Timing:
//   After the last transfer the sequencer enters the drain state, and
//   the first pop fills the output register. Results then follow at
//   1 per cycle while m_ready does not stall, limited by the single-cell
//   shift of the chain. s_ready is low while the chain drains.
// Reset (aresetn low, synchronous): chain emptied, counters cleared, no
//   result pending.
// Back-pressure: a stalled m_ready holds the output register and freezes the
//   drain; the held result is kept stable. Once the last result is in the
//   output register the next vector may start loading behind it.
`default_nettype none

module vector_sort_sum_argmax_unit
    import vssa_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire vssa_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output vssa_out_t      m_data
);

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t           state_reg;
    logic             m_valid_reg;
    vssa_out_t        m_data_reg;
    logic [CNT_W-1:0] remaining_reg;

    logic             in_xfer;
    logic             emit_fire;
    logic [CNT_W-1:0] n_vec;
    vssa_op_t         op;
    vssa_fill_t       fill;
    vssa_snap_t       snap;

    vssa_link_t       link_w  [DEPTH];
    vssa_link_t       left_w  [DEPTH];
    vssa_link_t       right_w [DEPTH];

    // Chain accepts new elements only while loading.
    assign s_ready   = (state_reg == ST_LOAD);
    assign in_xfer   = s_valid && s_ready;
    // While draining, pop cell 0 whenever the output register is free or being emptied.
    assign emit_fire = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    assign op.insert = in_xfer && !fill.full;
    assign op.shift  = emit_fire;

    // Elements held once this transfer is in: dropped final adds nothing.
    assign n_vec = fill.full ? fill.count : fill.count + 1'b1;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    vssa_stats u_stats (
        .aclk    (aclk),
        .aresetn (aresetn),
        .xfer    (in_xfer),
        .item    (s_data),
        .fill    (fill),
        .snap    (snap)
    );

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign left_w[i] = LINK_HEAD;
        end else begin : g_left
            assign left_w[i] = link_w[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign right_w[i] = LINK_TAIL;
        end else begin : g_right
            assign right_w[i] = link_w[i+1];
        end

        vssa_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .op      (op),
            .key     (s_data.value),
            .left    (left_w[i]),
            .right   (right_w[i]),
            .link    (link_w[i])
        );
    end

    // Sequencer: load, then drain remaining_reg results.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            m_valid_reg   <= 1'b0;
            remaining_reg <= '0;
        end else begin
            // a pop refills the register in the same cycle
            if (m_valid_reg && m_ready && !emit_fire) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD: begin
                    if (in_xfer && s_data.last) begin
                        state_reg     <= ST_EMIT;
                        remaining_reg <= n_vec;
                    end
                end
                ST_EMIT: begin
                    if (emit_fire) begin
                        m_valid_reg   <= 1'b1;
                        remaining_reg <= remaining_reg - 1'b1;
                        if (remaining_reg == CNT_W'(1)) begin
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
        if (emit_fire) begin
            m_data_reg <= '{sorted_value: link_w[0].value,
                            final_res:    (remaining_reg == CNT_W'(1)),
                            total:        snap.total,
                            max_position: snap.max_position,
                            overflow:     snap.overflow};
        end
    end

    // Draining never starts or continues with nothing left to send.
    a_emit_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (remaining_reg != '0))
        else $error("drain state with no results left");

    // Sending the final result returns the block to loading.
    a_emit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_fire && remaining_reg == CNT_W'(1)) |=> (state_reg == ST_LOAD))
        else $error("sequencer did not return to load after final result");

    // Every popped result comes from an occupied head cell.
    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire |-> link_w[0].valid)
        else $error("pop from empty chain");

    // The front of the chain stays in ascending order.
    a_head_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (link_w[0].valid && link_w[1].valid) |-> !(link_w[1].value < link_w[0].value))
        else $error("chain out of order");

endmodule

`default_nettype wire

[verif/vssa_scoreboard_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard for the vector sort / sum / argmax unit: predicts the sorted
// results of each vector and checks the received results against them.
// Depends on vssa_pkg for the transfer structs and sizes.

package vssa_scoreboard_pkg;

    import vssa_pkg::*;

    class vssa_sort_scoreboard;

        // Copy of the block state for the vector being loaded
        logic signed [VAL_W-1:0] stored_vals [DEPTH];
        int unsigned             fill_count;
        logic signed [VAL_W-1:0] run_total;
        logic signed [VAL_W-1:0] peak_value;
        logic [POS_W-1:0]        peak_pos;
        logic                    dropped;

        vssa_out_t   sorted_q [$];
        int unsigned errors;
        int unsigned elements_in;
        int unsigned vectors_done;
        int unsigned overflow_vectors;
        int unsigned results_checked;

        function new();
            errors           = 0;
            elements_in      = 0;
            vectors_done     = 0;
            overflow_vectors = 0;
            results_checked  = 0;
            clear_vector();
        endfunction

        function void clear_vector();
            fill_count = 0;
            run_total  = '0;
            peak_pos   = '0;
            dropped    = 1'b0;
        endfunction

        function int unsigned pending();
            return sorted_q.size();
        endfunction

        task report_mismatch(input string msg);
            errors++;
            if (errors <= 30)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        // Accepted input transfer: update the state, and on the final
        // element queue the whole sorted vector.
        function void note_input(input vssa_in_t item);
            logic signed [VAL_W-1:0] ordered [DEPTH];
            logic signed [VAL_W-1:0] key;
            vssa_out_t               res;
            int                      n;
            int                      i;
            int                      j;

            elements_in++;
            if (fill_count < DEPTH) begin
                stored_vals[fill_count] = item.value;
                run_total = run_total + item.value;
                // strict compare keeps the earliest of equal maxima
                if (fill_count == 0 || item.value > peak_value) begin
                    peak_value = item.value;
                    peak_pos   = POS_W'(fill_count);
                end
                fill_count++;
            end else begin
                dropped = 1'b1;
            end

            if (!item.last)
                return;

            n = fill_count;
            for (i = 0; i < n; i++) begin
                key = stored_vals[i];
                j   = i;
                while (j > 0 && key < ordered[j-1]) begin
                    ordered[j] = ordered[j-1];
                    j--;
                end
                ordered[j] = key;
            end

            for (i = 0; i < n; i++) begin
                res.sorted_value = ordered[i];
                res.final_res    = (i == n - 1);
                res.total        = run_total;
                res.max_position = peak_pos;
                res.overflow     = dropped;
                sorted_q.push_back(res);
            end

            vectors_done++;
            if (dropped)
                overflow_vectors++;
            clear_vector();
        endfunction

        // Accepted result transfer: compare with the oldest expectation.
        task check_result(input vssa_out_t got);
            vssa_out_t want;

            results_checked++;
            if (sorted_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result, sorted_value %0d",
                                          got.sorted_value));
                return;
            end
            want = sorted_q.pop_front();
            if (got.sorted_value !== want.sorted_value)
                report_mismatch($sformatf("sorted_value got %0d want %0d",
                                          got.sorted_value, want.sorted_value));
            if (got.final_res !== want.final_res)
                report_mismatch($sformatf("final_res got %b want %b",
                                          got.final_res, want.final_res));
            if (got.total !== want.total)
                report_mismatch($sformatf("total got %0d want %0d",
                                          got.total, want.total));
            if (got.max_position !== want.max_position)
                report_mismatch($sformatf("max_position got %0d want %0d",
                                          got.max_position, want.max_position));
            if (got.overflow !== want.overflow)
                report_mismatch($sformatf("overflow got %b want %b",
                                          got.overflow, want.overflow));
        endtask

    endclass

endpackage

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Top-level testbench for vector_sort_sum_argmax_unit: directed vectors, then
// random vectors under four idling phases. Depends on vssa_pkg and
// vssa_scoreboard_pkg.

module tb_top;

    import vssa_pkg::*;
    import vssa_scoreboard_pkg::*;

    localparam int ITEMS_PER_PHASE = 125;
    localparam int DRAIN_CYCLES    = 4 * DEPTH;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    vssa_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    vssa_out_t m_data;

    // Percentages of cycles in which the sender idles / the receiver stalls
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    vssa_sort_scoreboard sb = new();

    vector_sort_sum_argmax_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Receiver: m_ready redrawn every cycle from the current stall rate.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: values read at the rising edge are those before the edge,
    // so both transfers seen here are the ones completed at this edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_data);
            if (s_valid && s_ready)
                sb.note_input(s_data);
        end
    end

    // Present one element and hold it until the transfer completes. Valid is
    // left high afterwards; an idling next call or the end of stimulus
    // lowers it, so it is never lowered and raised in the same step.
    task automatic send_item(input logic signed [VAL_W-1:0] value, input logic last);
        vssa_in_t item;

        item.value = value;
        item.last  = last;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Mix of full-range values, a narrow band (plenty of ties for the
    // maximum), the extremes of the signed range and -1000 to 1000.
    function automatic logic signed [VAL_W-1:0] pick_value();
        int unsigned sel;

        sel = $urandom_range(0, 99);
        if (sel < 40)
            return $urandom;
        else if (sel < 60)
            return $urandom_range(0, 8) - 4;
        else if (sel < 75) begin
            case ($urandom_range(0, 5))
                0: return 32'sh8000_0000;
                1: return 32'sh8000_0001;
                2: return 32'sh7FFF_FFFF;
                3: return 32'sh7FFF_FFFE;
                4: return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        return $urandom_range(0, 2000) - 1000;
    endfunction

    // Mostly short vectors; long ones are handled separately per phase.
    function automatic int pick_length();
        int unsigned sel;

        sel = $urandom_range(0, 99);
        if (sel < 72)
            return $urandom_range(1, 6);
        else if (sel < 92)
            return $urandom_range(7, 24);
        return $urandom_range(25, DEPTH - 1);
    endfunction

    task automatic send_vector(input int len);
        int i;

        for (i = 0; i < len; i++)
            send_item(pick_value(), i == len - 1);
    endtask

    // One idling phase of random vectors. The third vector exactly fills
    // the store and the fifth spills over it, if the phase reaches them, so
    // the dropped elements (final one included) and the overflow flag show.
    task automatic run_phase(input int idle_pct, input int stall_pct);
        int items;
        int vec_idx;
        int len;

        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        items   = 0;
        vec_idx = 0;
        while (items < ITEMS_PER_PHASE) begin
            if (vec_idx == 2)
                len = DEPTH;
            else if (vec_idx == 4)
                len = $urandom_range(DEPTH + 1, DEPTH + 6);
            else
                len = pick_length();
            send_vector(len);
            items += len;
            vec_idx++;
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed vectors, no idling.
        // single elements at the extremes
        send_item(32'sh0000_0000, 1'b1);
        send_item(32'sh7FFF_FFFF, 1'b1);
        send_item(32'sh8000_0000, 1'b1);
        send_item(-32'sd1,        1'b1);
        // tied maxima at the top of the range, sum wraps
        send_item(32'sh7FFF_FFFF, 1'b0);
        send_item(32'sh7FFF_FFFF, 1'b1);
        // two minima, sum wraps to zero
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh8000_0000, 1'b1);
        // tied maximum in the middle: first position must be kept
        send_item(32'sd3,  1'b0);
        send_item(32'sd7,  1'b0);
        send_item(32'sd7,  1'b0);
        send_item(-32'sd2, 1'b0);
        send_item(32'sd7,  1'b1);
        // descending input
        send_item(32'sd5, 1'b0);
        send_item(32'sd4, 1'b0);
        send_item(32'sd3, 1'b0);
        send_item(32'sd2, 1'b0);
        send_item(32'sd1, 1'b1);
        // both extremes plus zero
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh7FFF_FFFF, 1'b0);
        send_item(32'sh0000_0000, 1'b1);

        // Random vectors under each idling pattern
        run_phase(0, 0);
        run_phase(46, 0);
        run_phase(0, 46);
        run_phase(36, 36);

        s_valid <= 1'b0;

        // Wait for every queued result, then give the block time to show
        // any stray extra one.
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

        $display("Sorted %0d vectors from %0d elements (%0d overflowing the store)",
                 sb.vectors_done, sb.elements_in, sb.overflow_vectors);
        $display("Checked %0d results in all four idling phases; %0d mismatches",
                 sb.results_checked, sb.errors);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: far beyond the slowest legitimate run.
    initial begin
        #1000000;
        $display("Timeout: %0d results still outstanding", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
